// ===== hw/rtl/sads_pkg.sv =====
// Package: shared types and codes of the dual stack on a shared array.
`timescale 1ns / 1ps
`default_nettype none
package sads_pkg;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef struct packed {
      logic [1:0]         command;
      logic               stack_select;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic               lower_empty;
      logic               upper_empty;
      logic               both_full;
   } rsp_type;

   // Result fields known at issue time; the read data arrives in the cycle after issue.
   typedef struct packed {
      logic [1:0] status;
      logic       use_read;
      logic       lower_empty;
      logic       upper_empty;
      logic       both_full;
   } pend_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sads_mem.sv =====
// Module: single-port synchronous RAM holding both stacks.
`timescale 1ns / 1ps
`default_nettype none
module sads_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 4
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic                  re,
   input  wire logic [ADDR_W-1:0]     addr,
   input  wire logic [DATA_WIDTH-1:0] wdata,
   output logic      [DATA_WIDTH-1:0] rdata
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sads_ctrl.sv =====
// Module: stack pointers, memory access issue and result register.
`timescale 1ns / 1ps
`default_nettype none
module sads_ctrl #(
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 4,
   parameter int CNT_W      = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CNT_W-1:0]      capacity,
   input  wire logic                  clear,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sads_pkg::req_type     req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sads_pkg::rsp_type          rsp_payload,
   output logic                       mem_we,
   output logic                       mem_re,
   output logic      [ADDR_W-1:0]     mem_addr,
   output logic      [DATA_WIDTH-1:0] mem_wdata,
   input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

   logic [CNT_W-1:0]   lower_ff, lower_in;
   logic [CNT_W-1:0]   upper_ff, upper_in;
   logic               pend_valid_ff, pend_valid_in;
   sads_pkg::pend_type pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sads_pkg::rsp_type  rsp_ff, rsp_in;

   logic             accept, move, full;
   logic [CNT_W:0]   used, used_in;
   logic [CNT_W-1:0] addr_wide;
   logic [31:0]      rd_ext;

   assign move      = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   assign used = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign full = used >= {1'b0, capacity};

   generate
      if (DATA_WIDTH > 32) begin : g_wide
         assign mem_wdata = {{(DATA_WIDTH - 32){req_payload.push_value[31]}},
                             req_payload.push_value};
         assign rd_ext    = mem_rdata[31:0];
      end else if (DATA_WIDTH == 32) begin : g_equal
         assign mem_wdata = req_payload.push_value;
         assign rd_ext    = mem_rdata;
      end else begin : g_narrow
         assign mem_wdata = req_payload.push_value[DATA_WIDTH-1:0];
         assign rd_ext    = {{(32 - DATA_WIDTH){mem_rdata[DATA_WIDTH-1]}}, mem_rdata};
      end
   endgenerate

   always_comb begin
      lower_in       = lower_ff;
      upper_in       = upper_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      addr_wide      = '0;
      pend_in.status   = sads_pkg::ST_OK;
      pend_in.use_read = 1'b0;
      case (req_payload.command)
         sads_pkg::CMD_PUSH: begin
            if (full) begin
               pend_in.status = sads_pkg::ST_FULL;
            end else if (req_payload.stack_select) begin
               upper_in  = upper_ff + CNT_W'(1);
               addr_wide = capacity - upper_in;
               mem_we    = accept;
            end else begin
               lower_in  = lower_ff + CNT_W'(1);
               addr_wide = lower_ff;
               mem_we    = accept;
            end
         end
         sads_pkg::CMD_POP, sads_pkg::CMD_PEEK: begin
            if (req_payload.stack_select) begin
               if (upper_ff == '0) begin
                  pend_in.status = sads_pkg::ST_EMPTY;
               end else begin
                  addr_wide        = capacity - upper_ff;
                  mem_re           = accept;
                  pend_in.use_read = 1'b1;
                  if (req_payload.command == sads_pkg::CMD_POP) begin
                     upper_in = upper_ff - CNT_W'(1);
                  end
               end
            end else begin
               if (lower_ff == '0) begin
                  pend_in.status = sads_pkg::ST_EMPTY;
               end else begin
                  addr_wide        = lower_ff - CNT_W'(1);
                  mem_re           = accept;
                  pend_in.use_read = 1'b1;
                  if (req_payload.command == sads_pkg::CMD_POP) begin
                     lower_in = lower_ff - CNT_W'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      used_in             = {1'b0, lower_in} + {1'b0, upper_in};
      pend_in.lower_empty = (lower_in == '0);
      pend_in.upper_empty = (upper_in == '0);
      pend_in.both_full   = used_in >= {1'b0, capacity};
   end

   assign mem_addr = addr_wide[ADDR_W-1:0];

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (move) begin
         pend_valid_in = 1'b0;
      end
      if (accept) begin
         pend_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (move) begin
         rsp_valid_in = 1'b1;
      end
      rsp_in.status      = pend_ff.status;
      rsp_in.read_value  = pend_ff.use_read ? rd_ext : 32'sd0;
      rsp_in.lower_empty = pend_ff.lower_empty;
      rsp_in.upper_empty = pend_ff.upper_empty;
      rsp_in.both_full   = pend_ff.both_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff      <= '0;
         upper_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (clear) begin
            lower_ff <= '0;
            upper_ff <= '0;
         end else if (accept) begin
            lower_ff <= lower_in;
            upper_ff <= upper_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/shared_array_dual_stack.sv =====
// Top level: two stacks sharing one RAM, with request/response channels and CSR port.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  sads_pkg::req_type (command, stack, value)
//  rsp_      out        rsp_valid/rsp_stall  sads_pkg::rsp_type (status, data, flags)
//  csr       in/out     psel/penable/pready  capacity register at byte address 0
//
//  One transaction per cycle sustained while the response is not stalled; a taken
//  request updates the pointers and accesses the RAM, then the pending fields and
//  the RAM read data are registered into the response register when the response
//  is free. The single RAM port sets the rate.
//  Reset clears both stack counts and the response pipeline; capacity returns to
//  min(16, DEPTH). RAM contents are not cleared.
//  A stalled response holds the pending transaction, which then stalls requests.
//
module shared_array_dual_stack #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sads_pkg::req_type req_payload,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sads_pkg::rsp_type      rsp_payload,
   // configuration port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

   logic [CNT_W-1:0]      capacity_ff, capacity_in;
   logic                  cap_write;
   logic [4:0]            cap_raw;
   int                    cap_clamped;

   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   // APB: no wait states; register index is the word address bit.
   assign pready    = 1'b1;
   assign cap_write = psel && penable && pwrite && (paddr[2] == sads_pkg::CSR_IDX_CAPACITY);
   assign cap_raw   = pwdata[4:0];

   // Capacity saturates to the range 1..DEPTH.
   always_comb begin
      cap_clamped = int'(cap_raw);
      if (cap_clamped < 1) begin
         cap_clamped = 1;
      end else if (cap_clamped > DEPTH) begin
         cap_clamped = DEPTH;
      end
      capacity_in = CNT_W'(cap_clamped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CNT_W'(CAP_RESET);
      end else if (cap_write) begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == sads_pkg::CSR_IDX_CAPACITY) begin
         prdata = 32'(capacity_ff);
      end
   end

   // Pointers, issue and response register; the capacity write empties both stacks.
   sads_ctrl #(
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .clear       (cap_write),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mem_we      (mem_we),
      .mem_re      (mem_re),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rdata   (mem_rdata)
   );

   // Shared storage: lower stack from entry 0 up, upper stack from capacity-1 down.
   sads_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule
`default_nettype wire
